/* rtl/lhsd_pkg.sv */
// Shared types, constants and bit-routing function for the LED hold timer serial driver.
// Used by every module of the block; depends on nothing.
`default_nettype none

package lhsd_pkg;

  // Opcodes of an input beat
  localparam logic [1:0] OP_SET_DEFAULT = 2'd0;
  localparam logic [1:0] OP_SET_GIVEN   = 2'd1;
  localparam logic [1:0] OP_TICK        = 2'd2;
  localparam logic [1:0] OP_DIRECT      = 2'd3;

  localparam int NumLeds       = 8;
  localparam int LedIdxW       = 3;
  localparam int HoldW         = 16;
  localparam int CountWidthDef = 16;
  localparam logic [HoldW-1:0] DefaultHoldReset = 16'd2000;

  // Input beat: led_index, hold_time, pattern, zero pad; opcode rides on tuser
  localparam int InDataW  = 32;
  // Output beat: serial_bit, shown_pattern, zero pad
  localparam int OutDataW = 16;

  // Depth of the queue between classifier and serializer
  localparam int QueueDepth = 2;
  localparam int QueuePtrW  = 1;
  localparam int QueueCntW  = 2;

  // Logical bit i drives physical bit LedRoute[i]
  localparam logic [2:0] LedRoute [NumLeds] = '{3'd3, 3'd2, 3'd7, 3'd1,
                                                3'd6, 3'd0, 3'd5, 3'd4};

  // Pattern handed from front to back
  typedef struct packed {
    logic                 valid;
    logic [NumLeds-1:0]   pattern;
  } lhsd_push_t;

  // Route a logical LED byte to the physical shift-register order, active low
  function automatic logic [NumLeds-1:0] route_invert(input logic [NumLeds-1:0] logical);
    logic [NumLeds-1:0] phys;
    phys = '0;
    for (int i = 0; i < NumLeds; i++) begin
      phys[LedRoute[i]] = logical[i];
    end
    return ~phys;
  endfunction

endpackage

`default_nettype wire

/* rtl/lhsd_front.sv */
// Front end: accepts input beats, holds the configured default and the eight hold counters,
// and forms the logical LED byte for ticks and direct writes. Depends on lhsd_pkg.
`default_nettype none

module lhsd_front #(
  parameter int COUNT_WIDTH = lhsd_pkg::CountWidthDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [lhsd_pkg::HoldW-1:0]     cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [1:0]                     opcode_i,
  input  logic [lhsd_pkg::LedIdxW-1:0]   led_index_i,
  input  logic [lhsd_pkg::HoldW-1:0]     hold_time_i,
  input  logic [lhsd_pkg::NumLeds-1:0]   pattern_i,
  input  logic                           q_full_i,
  output lhsd_pkg::lhsd_push_t           push_o
);
  import lhsd_pkg::*;

  localparam int ExtW = (COUNT_WIDTH > HoldW) ? COUNT_WIDTH : HoldW;

  logic [HoldW-1:0]       default_hold_q;
  logic [COUNT_WIDTH-1:0] cnt_q [NumLeds];
  logic [COUNT_WIDTH-1:0] cnt_d [NumLeds];
  logic                   accept;
  logic [HoldW-1:0]       load_src;
  logic [ExtW-1:0]        load_ext;
  logic [ExtW-1:0]        cnt_max_ext;
  logic [COUNT_WIDTH-1:0] load_val;
  logic [NumLeds-1:0]     lit;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !q_full_i;
  assign accept      = in_valid_i && in_ready_o;

  // Configured default hold
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      default_hold_q <= DefaultHoldReset;
    end else if (cfg_valid_i) begin
      default_hold_q <= cfg_data_i;
    end
  end

  // Saturate the loaded hold at the counter width
  assign load_src    = (opcode_i == OP_SET_GIVEN) ? hold_time_i : default_hold_q;
  assign load_ext    = ExtW'(load_src);
  assign cnt_max_ext = ExtW'({COUNT_WIDTH{1'b1}});
  assign load_val    = (load_ext > cnt_max_ext) ? {COUNT_WIDTH{1'b1}}
                                                : load_ext[COUNT_WIDTH-1:0];

  // Counter updates: load one on a set, decrement the live ones on a tick
  always_comb begin
    for (int i = 0; i < NumLeds; i++) begin
      lit[i]   = (cnt_q[i] != '0);
      cnt_d[i] = cnt_q[i];
      if (accept) begin
        unique case (opcode_i) inside
          OP_SET_DEFAULT, OP_SET_GIVEN: begin
            if (led_index_i == LedIdxW'(i)) cnt_d[i] = load_val;
          end
          OP_TICK: begin
            if (lit[i]) cnt_d[i] = cnt_q[i] - COUNT_WIDTH'(1);
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumLeds; i++) cnt_q[i] <= '0;
    end else begin
      for (int i = 0; i < NumLeds; i++) cnt_q[i] <= cnt_d[i];
    end
  end

  // Ticks and direct writes hand a logical byte to the serializer
  assign push_o.valid   = accept && (opcode_i == OP_TICK || opcode_i == OP_DIRECT);
  assign push_o.pattern = (opcode_i == OP_TICK) ? lit : pattern_i;

endmodule

`default_nettype wire

/* rtl/lhsd_queue.sv */
// Short queue of logical LED bytes between front end and serializer.
// Depends on lhsd_pkg.
`default_nettype none

module lhsd_queue (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  lhsd_pkg::lhsd_push_t           push_i,
  output logic                           full_o,
  input  logic                           pop_i,
  output logic                           empty_o,
  output logic [lhsd_pkg::NumLeds-1:0]   head_o
);
  import lhsd_pkg::*;

  logic [NumLeds-1:0]   mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QueueCntW-1:0] count_q;
  logic                 do_push, do_pop;

  assign full_o  = (count_q == QueueCntW'(QueueDepth));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i.valid && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= push_i.pattern;
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + QueuePtrW'(1);
      if (do_pop)  rd_ptr_q <= rd_ptr_q + QueuePtrW'(1);
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + QueueCntW'(1);
        2'b01:   count_q <= count_q - QueueCntW'(1);
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/lhsd_back.sv */
// Serializer: routes and inverts a logical byte, then shifts it out MSB first, one
// output beat per bit, flagging the eighth as last. Depends on lhsd_pkg.
`default_nettype none

module lhsd_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           q_empty_i,
  input  logic [lhsd_pkg::NumLeds-1:0]   q_head_i,
  output logic                           q_pop_o,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           serial_bit_o,
  output logic                           last_bit_o,
  output logic [lhsd_pkg::NumLeds-1:0]   shown_pattern_o
);
  import lhsd_pkg::*;

  logic               valid_q;
  logic [LedIdxW-1:0] bit_cnt_q;
  logic [NumLeds-1:0] shift_q;
  logic [NumLeds-1:0] logical_q;
  logic               last;
  logic               free;

  assign last    = (bit_cnt_q == LedIdxW'(NumLeds - 1));
  // Output slot frees up when empty or when the last bit is taken
  assign free    = !valid_q || (out_ready_i && last);
  assign q_pop_o = free && !q_empty_i;

  // Control: valid flag and bit position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= 1'b0;
      bit_cnt_q <= '0;
    end else if (free) begin
      valid_q   <= !q_empty_i;
      bit_cnt_q <= '0;
    end else if (out_ready_i) begin
      bit_cnt_q <= bit_cnt_q + LedIdxW'(1);
    end
  end

  // Payload: physical shift register and the logical byte shown
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      shift_q   <= route_invert(q_head_i);
      logical_q <= q_head_i;
    end else if (valid_q && out_ready_i) begin
      shift_q   <= {shift_q[NumLeds-2:0], 1'b0};
    end
  end

  assign out_valid_o     = valid_q;
  assign serial_bit_o    = shift_q[NumLeds-1];
  assign last_bit_o      = last;
  assign shown_pattern_o = logical_q;

endmodule

`default_nettype wire

/* rtl/led_hold_timers_serial_driver.sv */
// Top level of the LED hold timer serial driver: streaming ports, config port, and the
// front end, queue and serializer. Depends on lhsd_pkg, lhsd_front, lhsd_queue, lhsd_back.
`default_nettype none

// Eight activity LEDs, each with a hold counter. Set beats (opcode 0/1) load one counter and
// produce no output; a tick (2) lights every LED with a nonzero counter and counts those
// down; a direct write (3) shows a raw byte. The opcode travels on tuser. Each tick or direct
// write yields eight output beats, the routed and inverted byte MSB first, the eighth with
// tlast for the strobe.
// Set beats are taken one per cycle while the queue is not full; a tick or direct write
// occupies the serializer for eight output beats (one bit per cycle while the output is ready).
// A two-entry queue lets the front end accept beats while the serializer is busy or the
// output is stalled. The counters reset to zero, default_hold to 2000; no clearing pass.
module led_hold_timers_serial_driver #(
  parameter int COUNT_WIDTH = lhsd_pkg::CountWidthDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Config: default_hold
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [lhsd_pkg::HoldW-1:0]      cfg_data_i,
  // Input: led_index[2:0], hold_time[18:3], pattern[26:19], zero[31:27]
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [lhsd_pkg::InDataW-1:0]    s_axis_tdata,
  // Input: opcode[1:0]
  input  logic [1:0]                      s_axis_tuser,
  // Output: serial_bit[0], shown_pattern[8:1], zero[15:9]; last_bit on tlast
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [lhsd_pkg::OutDataW-1:0]   m_axis_tdata,
  output logic                            m_axis_tlast
);
  import lhsd_pkg::*;

  lhsd_push_t         push;
  logic               q_full, q_empty, q_pop;
  logic [NumLeds-1:0] q_head;
  logic               serial_bit;
  logic [NumLeds-1:0] shown_pattern;

  lhsd_front #(.COUNT_WIDTH(COUNT_WIDTH)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .opcode_i    (s_axis_tuser),
    .led_index_i (s_axis_tdata[2:0]),
    .hold_time_i (s_axis_tdata[18:3]),
    .pattern_i   (s_axis_tdata[26:19]),
    .q_full_i    (q_full),
    .push_o      (push)
  );

  lhsd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .head_o  (q_head)
  );

  lhsd_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_empty_i       (q_empty),
    .q_head_i        (q_head),
    .q_pop_o         (q_pop),
    .out_valid_o     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .serial_bit_o    (serial_bit),
    .last_bit_o      (m_axis_tlast),
    .shown_pattern_o (shown_pattern)
  );

  assign m_axis_tdata = {(OutDataW - NumLeds - 1)'(0), shown_pattern, serial_bit};

endmodule

`default_nettype wire

/* sim/tb_led_hold_timers_serial_driver.sv */
// Testbench for the LED hold timer serial driver: directed and random command beats,
// a built-in predictor of the hold counters and serial output, and a beat-by-beat check.
// Depends on lhsd_pkg and led_hold_timers_serial_driver.
`timescale 1ns / 1ps

module tb_led_hold_timers_serial_driver;

  localparam int CountW     = 16;
  localparam int MaxCycles  = 200000;
  localparam int SettleCyc  = 16;
  localparam int GapPercent = 15;

  // Logical LED i lands on shift-register bit led_map[i]
  localparam logic [2:0] led_map [8] = '{3'd3, 3'd2, 3'd7, 3'd1, 3'd6, 3'd0, 3'd5, 3'd4};

  typedef struct packed {
    logic [1:0]  op;
    logic [2:0]  idx;
    logic [15:0] hold;
    logic [7:0]  pat;
  } led_cmd_t;

  typedef struct packed {
    logic       serial;
    logic       last;
    logic [7:0] shown;
  } led_bit_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;  // led_index[2:0], hold_time[18:3], pattern[26:19]
  logic [1:0]  s_axis_tuser = '0;  // opcode[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;   // serial_bit[0], shown_pattern[8:1], zero pad[15:9]
  logic        m_axis_tlast;

  // Predictor state
  logic [CountW-1:0] hold_cnt [8];
  logic [15:0]       hold_default;
  led_bit_t          bits_due [$];
  led_cmd_t          cmds_pending [$];

  // Driver and monitor bookkeeping
  led_cmd_t drv_cmd;
  led_bit_t want_bit;
  bit       in_beat_taken;
  bit       src_gaps;
  bit       sink_gaps;
  int       fail_count = 0;
  int       cycle_count = 0;

  led_hold_timers_serial_driver #(.COUNT_WIDTH(CountW)) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // 4 ns clock
  initial clk_i = 1'b0;
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Clamp a loaded hold time to what the counter can hold
  function automatic logic [CountW-1:0] clamp_hold(input logic [15:0] v);
    logic [31:0] top;
    top = (CountW >= 32) ? 32'hFFFF_FFFF : ((32'd1 << CountW) - 32'd1);
    if ({16'd0, v} > top) return top[CountW-1:0];
    return CountW'(v);
  endfunction

  // Queue the eight serial beats of one shown byte, MSB first
  task automatic queue_serial(input logic [7:0] shown);
    logic [7:0] phys;
    led_bit_t   b;
    phys = '0;
    for (int i = 0; i < 8; i++) phys[led_map[i]] = shown[i];
    phys = ~phys;
    for (int i = 0; i < 8; i++) begin
      b.serial = phys[7-i];
      b.last   = (i == 7);
      b.shown  = shown;
      bits_due.push_back(b);
    end
  endtask

  // Apply one accepted command to the hold counters
  task automatic predict_cmd(input led_cmd_t c);
    logic [7:0] lit;
    lit = '0;
    case (c.op)
      lhsd_pkg::OP_SET_DEFAULT: hold_cnt[c.idx] = clamp_hold(hold_default);
      lhsd_pkg::OP_SET_GIVEN:   hold_cnt[c.idx] = clamp_hold(c.hold);
      lhsd_pkg::OP_TICK: begin
        for (int i = 0; i < 8; i++) begin
          if (hold_cnt[i] != '0) begin
            hold_cnt[i] = hold_cnt[i] - CountW'(1);
            lit[i] = 1'b1;
          end
        end
        queue_serial(lit);
      end
      default: queue_serial(c.pat);
    endcase
  endtask

  task automatic add_cmd(input logic [1:0] op, input logic [2:0] idx,
                         input logic [15:0] hold, input logic [7:0] pat);
    led_cmd_t c;
    c.op   = op;
    c.idx  = idx;
    c.hold = hold;
    c.pat  = pat;
    cmds_pending.push_back(c);
  endtask

  // Random command, mostly short holds so ticks see LEDs expire
  task automatic add_random_cmd();
    int         pick;
    logic [1:0] op;
    logic [15:0] hold;
    pick = $urandom_range(99);
    if (pick < 20)      op = lhsd_pkg::OP_SET_DEFAULT;
    else if (pick < 50) op = lhsd_pkg::OP_SET_GIVEN;
    else if (pick < 85) op = lhsd_pkg::OP_TICK;
    else                op = lhsd_pkg::OP_DIRECT;
    hold = ($urandom_range(99) < 70) ? 16'($urandom_range(6)) : 16'($urandom_range(65535));
    add_cmd(op, 3'($urandom_range(7)), hold, 8'($urandom_range(255)));
  endtask

  // Hold off until every command is in and every beat is out, then let the block settle
  task automatic wait_drained();
    while (cmds_pending.size() != 0 || s_axis_tvalid || bits_due.size() != 0)
      @(posedge clk_i);
    repeat (SettleCyc) @(posedge clk_i);
  endtask

  task automatic write_hold_default(input logic [15:0] v);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Input driver and output back-pressure, changed on the falling edge
  always @(negedge clk_i) begin
    if (!s_axis_tvalid || in_beat_taken) begin
      if (cmds_pending.size() != 0 && !(src_gaps && $urandom_range(99) < GapPercent)) begin
        drv_cmd = cmds_pending.pop_front();
        s_axis_tdata  <= {5'b00000, drv_cmd.pat, drv_cmd.hold, drv_cmd.idx};
        s_axis_tuser  <= drv_cmd.op;
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
    m_axis_tready <= !(sink_gaps && $urandom_range(99) < GapPercent);
  end

  // Monitor: predict on accepted commands, check each output beat
  always @(posedge clk_i) begin
    in_beat_taken = s_axis_tvalid && s_axis_tready;
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) hold_cnt[i] = '0;
      hold_default = 16'd2000;
    end else begin
      if (cfg_valid_i && cfg_ready_o) hold_default = cfg_data_i;
      if (in_beat_taken)
        predict_cmd(led_cmd_t'({s_axis_tuser, s_axis_tdata[2:0], s_axis_tdata[18:3],
                                s_axis_tdata[26:19]}));
      if (m_axis_tvalid && m_axis_tready) begin
        if (bits_due.size() == 0) begin
          $display("%0t: unexpected beat tdata=%h tlast=%b", $time, m_axis_tdata, m_axis_tlast);
          fail_count++;
        end else begin
          want_bit = bits_due.pop_front();
          if (m_axis_tdata[0] !== want_bit.serial) begin
            $display("%0t: serial_bit expected %b actual %b", $time, want_bit.serial,
                     m_axis_tdata[0]);
            fail_count++;
          end
          if (m_axis_tlast !== want_bit.last) begin
            $display("%0t: last_bit expected %b actual %b", $time, want_bit.last, m_axis_tlast);
            fail_count++;
          end
          if (m_axis_tdata[8:1] !== want_bit.shown) begin
            $display("%0t: shown_pattern expected %h actual %h", $time, want_bit.shown,
                     m_axis_tdata[8:1]);
            fail_count++;
          end
          if (m_axis_tdata[15:9] !== 7'd0) begin
            $display("%0t: tdata pad expected 00 actual %h", $time, m_axis_tdata[15:9]);
            fail_count++;
          end
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= MaxCycles) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Stimulus sequence
  initial begin
    src_gaps      = 1'b1;
    sink_gaps     = 1'b1;
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: dark tick, direct-write extremes, set kinds, expiry, full-scale loads
    add_cmd(lhsd_pkg::OP_TICK,        3'd5, 16'hFFFF, 8'hFF);
    add_cmd(lhsd_pkg::OP_DIRECT,      3'd7, 16'hFFFF, 8'h00);
    add_cmd(lhsd_pkg::OP_DIRECT,      3'd0, 16'h0000, 8'hFF);
    add_cmd(lhsd_pkg::OP_DIRECT,      3'd2, 16'h1234, 8'h01);
    add_cmd(lhsd_pkg::OP_DIRECT,      3'd4, 16'h8000, 8'h80);
    add_cmd(lhsd_pkg::OP_DIRECT,      3'd1, 16'h5555, 8'hA5);
    add_cmd(lhsd_pkg::OP_SET_DEFAULT, 3'd0, 16'hABCD, 8'hFF);
    add_cmd(lhsd_pkg::OP_SET_GIVEN,   3'd7, 16'hFFFF, 8'h5A);
    add_cmd(lhsd_pkg::OP_SET_GIVEN,   3'd3, 16'h0001, 8'h00);
    add_cmd(lhsd_pkg::OP_SET_GIVEN,   3'd5, 16'h0000, 8'hFF);
    add_cmd(lhsd_pkg::OP_SET_GIVEN,   3'd1, 16'h0002, 8'hC3);
    add_cmd(lhsd_pkg::OP_TICK,        3'd2, 16'h0F0F, 8'h3C);
    add_cmd(lhsd_pkg::OP_TICK,        3'd6, 16'hF0F0, 8'h00);
    add_cmd(lhsd_pkg::OP_TICK,        3'd0, 16'h0000, 8'hFF);
    add_cmd(lhsd_pkg::OP_SET_GIVEN,   3'd6, 16'h0003, 8'h99);
    add_cmd(lhsd_pkg::OP_TICK,        3'd7, 16'hFFFF, 8'h66);
    wait_drained();

    // Default hold at zero loads a dark counter
    write_hold_default(16'd0);
    add_cmd(lhsd_pkg::OP_SET_DEFAULT, 3'd2, 16'h7777, 8'h11);
    add_cmd(lhsd_pkg::OP_TICK,        3'd3, 16'h0000, 8'h22);
    wait_drained();

    // Largest default hold
    write_hold_default(16'hFFFF);
    add_cmd(lhsd_pkg::OP_SET_DEFAULT, 3'd4, 16'h0000, 8'h44);
    add_cmd(lhsd_pkg::OP_TICK,        3'd1, 16'hAAAA, 8'h88);
    wait_drained();

    // Default of one: lit for exactly one tick
    write_hold_default(16'd1);
    add_cmd(lhsd_pkg::OP_SET_DEFAULT, 3'd6, 16'h0001, 8'h77);
    add_cmd(lhsd_pkg::OP_TICK,        3'd0, 16'h0000, 8'h00);
    add_cmd(lhsd_pkg::OP_TICK,        3'd5, 16'h0000, 8'hEE);
    wait_drained();

    // Random phases, each under its own default hold
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: write_hold_default(16'd3);
        1: write_hold_default(16'hFFFF);
        2: write_hold_default(16'd0);
        3: write_hold_default(16'($urandom_range(65535)));
        default: write_hold_default(16'($urandom_range(8)));
      endcase
      // one phase runs flat out on both sides
      src_gaps  = (ph != 2);
      sink_gaps = (ph != 2);
      for (int n = 0; n < 13; n++) add_random_cmd();
      if (ph == 3) wait_drained();
      for (int n = 0; n < 13; n++) add_random_cmd();
      wait_drained();
    end

    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/lhsd_pkg.sv
rtl/lhsd_front.sv
rtl/lhsd_queue.sv
rtl/lhsd_back.sv
rtl/led_hold_timers_serial_driver.sv
sim/tb_led_hold_timers_serial_driver.sv
